### src/decimal_id_obfuscation_codec_assert.svh
// Assertion macros for the decimal id obfuscation codec.
// Depends on nothing; included by the top level.
`ifndef DECIMAL_ID_OBFUSCATION_CODEC_ASSERT_SVH
`define DECIMAL_ID_OBFUSCATION_CODEC_ASSERT_SVH
`ifndef ASSERT_OFF
`define DIOC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DIOC_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DIOC_ASSERT(label, clk, rstn, prop, msg)
`define DIOC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### src/dioc_pkg.sv
// Shared types and constants of the decimal id obfuscation codec.
// No dependencies.
package dioc_pkg;
    localparam logic [63:0] TenPow19 = 64'd10000000000000000000;
    localparam logic [5:0] Sh1 = 6'd12;
    localparam logic [5:0] Sh2 = 6'd25;
    localparam logic [5:0] Sh3 = 6'd27;

    typedef enum logic [1:0] {
        REG_SECRET = 2'd0,
        REG_DIGITS = 2'd1,
        REG_MASK   = 2'd2
    } reg_index_t;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HASH,
        OP_MUL,
        OP_DIVISOR,
        OP_SPLIT,
        OP_COUNT,
        OP_COMBINE,
        OP_COMBINE2,
        OP_DEC_PREP,
        OP_DEC_SPLIT1,
        OP_DEC_SPLIT2,
        OP_DEC_FINAL,
        OP_MASK_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       div_start;
        logic       mul_start;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
        logic count_done;
        logic dec_bad;
    } dp_status_t;

    // 10^e, zero for e >= 19
    function automatic logic [63:0] ten_pow(input logic [5:0] e);
        logic [63:0] p;
        case (e)
            6'd0:    p = 64'd1;
            6'd1:    p = 64'd10;
            6'd2:    p = 64'd100;
            6'd3:    p = 64'd1000;
            6'd4:    p = 64'd10000;
            6'd5:    p = 64'd100000;
            6'd6:    p = 64'd1000000;
            6'd7:    p = 64'd10000000;
            6'd8:    p = 64'd100000000;
            6'd9:    p = 64'd1000000000;
            6'd10:   p = 64'd10000000000;
            6'd11:   p = 64'd100000000000;
            6'd12:   p = 64'd1000000000000;
            6'd13:   p = 64'd10000000000000;
            6'd14:   p = 64'd100000000000000;
            6'd15:   p = 64'd1000000000000000;
            6'd16:   p = 64'd10000000000000000;
            6'd17:   p = 64'd100000000000000000;
            6'd18:   p = 64'd1000000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction
endpackage

### src/dioc_div.sv
// Iterative radix-2 64-bit unsigned divider, one quotient bit per cycle.
// No dependencies; no instances.
module dioc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quot,
    output logic [63:0] rem
);
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [64:0] r_reg;
    logic [63:0] d_reg;
    logic [64:0] trial;

    assign trial = {r_reg[63:0], q_reg[63]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 7'd0;
        end else if (start) begin
            cnt_reg <= 7'd64;
            q_reg   <= dividend;
            r_reg   <= 65'd0;
            d_reg   <= divisor;
        end else if (cnt_reg != 7'd0) begin
            cnt_reg <= cnt_reg - 7'd1;
            if (!trial[64]) begin
                r_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= {r_reg[63:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != 7'd0);
    assign quot = q_reg;
    assign rem  = r_reg[63:0];
endmodule

### src/dioc_mul.sv
// 64x64 wrapping multiplier built from 32x32 partial products over cycles.
// No dependencies.
module dioc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic [63:0] prod
);
    logic [1:0]  step_reg;
    logic [63:0] a_reg, b_reg, acc_reg;
    logic [31:0] opx, opy;
    logic [63:0] pp_reg;
    logic        pp_vld_reg;
    logic [1:0]  pp_sel_reg;

    always_comb begin
        case (step_reg)
            2'd3:    begin opx = a_reg[31:0];  opy = b_reg[31:0];  end
            2'd2:    begin opx = a_reg[63:32]; opy = b_reg[31:0];  end
            default: begin opx = a_reg[31:0];  opy = b_reg[63:32]; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= 2'd0;
            pp_vld_reg <= 1'b0;
        end else begin
            pp_vld_reg <= (step_reg != 2'd0);
            pp_sel_reg <= step_reg;
            pp_reg     <= {32'd0, opx} * {32'd0, opy};
            if (start) begin
                step_reg <= 2'd3;
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= 64'd0;
            end else if (step_reg != 2'd0) begin
                step_reg <= step_reg - 2'd1;
            end
            if (pp_vld_reg && !start) begin
                if (pp_sel_reg == 2'd3) acc_reg <= acc_reg + pp_reg;
                else acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
            end
        end
    end

    assign busy = (step_reg != 2'd0) || pp_vld_reg;
    assign prod = acc_reg;
endmodule

### src/dioc_datapath.sv
// Datapath: hash, divisor, split, digit counting, combine, decode and masking registers.
// Depends on dioc_pkg, dioc_div, dioc_mul.
module dioc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  dioc_pkg::dp_cmd_t   cmd,
    output dioc_pkg::dp_status_t status,
    input  logic [63:0]         in_value,
    input  logic [63:0]         secret,
    input  logic [3:0]          digits,
    input  logic                mask_en,
    output logic [63:0]         res,
    output logic                bad
);
    logic [63:0] v_reg, h_reg, d_reg, r_reg, q_reg, acc_reg, cnt_v_reg;
    logic [5:0]  n_reg, k;
    logic        bad_reg;
    logic [63:0] base, h1, h2, h3;
    logic        div_start, mul_start;
    logic [63:0] div_a, div_b, mul_a, mul_b, quot, rem, prod;
    logic        div_busy, mul_busy;
    logic [63:0] masked;
    logic [63:0] mask_bits;
    logic [5:0]  tot;
    logic [63:0] pow_next;

    assign k    = (digits == 4'd0) ? 6'd1 : {2'b00, digits};
    assign base = dioc_pkg::ten_pow(k - 6'd1);

    function automatic logic [63:0] low_mask(input logic [63:0] v, input logic [63:0] s);
        logic [63:0] m;
        m = 64'd0;
        for (int i = 62; i >= 0; i--) m[i] = m[i + 1] | v[i + 1];
        return (v & ~m) | ((v ^ s) & m);
    endfunction

    assign h1 = v_reg ^ (v_reg >> dioc_pkg::Sh1);
    assign h2 = h1 ^ (h1 << dioc_pkg::Sh2);
    assign h3 = h2 ^ (h2 >> dioc_pkg::Sh3);
    assign masked = low_mask(acc_reg, secret);
    assign mask_bits = 64'd0;

    // next power of ten for the digit count; 10^19 still fits in 64 bits
    assign pow_next = (n_reg == 6'd18) ? dioc_pkg::TenPow19 : dioc_pkg::ten_pow(n_reg + 6'd1);

    dioc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .busy(div_busy), .quot(quot), .rem(rem)
    );
    dioc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .busy(mul_busy), .prod(prod)
    );

    // operand select per operation
    always_comb begin
        div_a = v_reg; div_b = d_reg; mul_a = h_reg; mul_b = secret | 64'd1;
        case (cmd.op)
            dioc_pkg::OP_MUL:       begin mul_a = h_reg; mul_b = secret | 64'd1; end
            dioc_pkg::OP_DIVISOR:   begin div_a = h_reg; div_b = base * 64'd9; end
            dioc_pkg::OP_SPLIT:     begin div_a = v_reg; div_b = d_reg; end
            dioc_pkg::OP_COMBINE:   begin mul_a = d_reg; mul_b = dioc_pkg::ten_pow(n_reg + k); end
            dioc_pkg::OP_COMBINE2:  begin mul_a = r_reg; mul_b = dioc_pkg::ten_pow(n_reg); end
            dioc_pkg::OP_DEC_SPLIT1:begin div_a = v_reg; div_b = dioc_pkg::ten_pow(tot - k); end
            dioc_pkg::OP_DEC_SPLIT2:begin
                div_a = h_reg; div_b = dioc_pkg::ten_pow(tot - k - k);
            end
            dioc_pkg::OP_DEC_FINAL: begin mul_a = d_reg; mul_b = q_reg; end
            default: ;
        endcase
    end
    assign div_start = cmd.div_start;
    assign mul_start = cmd.mul_start;

    assign tot = n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_reg <= 1'b0;
            n_reg   <= 6'd1;
        end else begin
            case (cmd.op)
                dioc_pkg::OP_LOAD: begin
                    v_reg   <= in_value;
                    bad_reg <= 1'b0;
                end
                dioc_pkg::OP_DEC_PREP: begin
                    // unmask input when masking is on, then count its digits
                    if (mask_en) v_reg <= low_mask(v_reg, secret);
                    cnt_v_reg <= mask_en ? low_mask(v_reg, secret) : v_reg;
                    n_reg <= 6'd1;
                end
                dioc_pkg::OP_HASH: h_reg <= h3;
                dioc_pkg::OP_DIVISOR: if (!div_busy && !cmd.div_start) d_reg <= rem + base;
                dioc_pkg::OP_SPLIT: if (!div_busy && !cmd.div_start) begin
                    r_reg <= rem; q_reg <= quot; cnt_v_reg <= quot; n_reg <= 6'd1;
                end
                dioc_pkg::OP_COUNT: if (cnt_v_reg >= 64'd10) begin
                    // one digit per cycle; clearing the value ends the count
                    n_reg <= n_reg + 6'd1;
                    if (n_reg == 6'd19 || cnt_v_reg < pow_next) cnt_v_reg <= 64'd0;
                end
                dioc_pkg::OP_MUL: if (!mul_busy && !cmd.mul_start) h_reg <= prod;
                // res = d*10^(k+n) + r*10^n + q, in two multiply passes
                dioc_pkg::OP_COMBINE: if (!mul_busy && !cmd.mul_start)
                    acc_reg <= prod + q_reg;
                dioc_pkg::OP_COMBINE2: if (!mul_busy && !cmd.mul_start)
                    acc_reg <= acc_reg + prod;
                dioc_pkg::OP_DEC_SPLIT1: begin
                    if (cmd.div_start) begin
                        if (tot < k + k + 6'd1 ||
                            dioc_pkg::ten_pow(tot - k) == 64'd0 ||
                            dioc_pkg::ten_pow(tot - k - k) == 64'd0) bad_reg <= 1'b1;
                    end else if (!div_busy) begin
                        d_reg <= quot; h_reg <= rem;
                    end
                end
                dioc_pkg::OP_DEC_SPLIT2: if (!div_busy && !cmd.div_start) begin
                    r_reg <= quot; q_reg <= rem;
                end
                dioc_pkg::OP_DEC_FINAL: if (!mul_busy && !cmd.mul_start)
                    acc_reg <= bad_reg ? 64'd0 : prod + r_reg;
                dioc_pkg::OP_MASK_OUT: if (mask_en) acc_reg <= masked;
                default: ;
            endcase
        end
    end

    assign res = acc_reg | mask_bits;
    assign bad = bad_reg;
    assign status.div_busy   = div_busy;
    assign status.mul_busy   = mul_busy;
    assign status.count_done = (cnt_v_reg < 64'd10);
    assign status.dec_bad    = bad_reg;
endmodule

### src/dioc_ctrl.sv
// Controller state machine sequencing the codec datapath.
// Depends on dioc_pkg.
module dioc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_cmd,
    output logic                 s_ready,
    output logic                 done,
    input  logic                 out_free,
    input  dioc_pkg::dp_status_t status,
    output dioc_pkg::dp_cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_HASH, ST_MUL, ST_DIV, ST_SPLIT, ST_COUNT, ST_COMB, ST_COMB2,
        ST_DPREP, ST_DCOUNT, ST_DS1, ST_DS2, ST_DFIN, ST_MASK, ST_DONE
    } state_t;

    state_t state_reg;
    logic   first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end else begin
            first_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:   if (s_valid) begin
                    state_reg <= s_cmd ? ST_DPREP : ST_HASH;
                end
                ST_HASH:   begin state_reg <= ST_MUL; first_reg <= 1'b1; end
                ST_MUL:    if (!first_reg && !status.mul_busy) begin
                    state_reg <= ST_DIV; first_reg <= 1'b1;
                end
                ST_DIV:    if (!first_reg && !status.div_busy) begin
                    state_reg <= ST_SPLIT; first_reg <= 1'b1;
                end
                ST_SPLIT:  if (!first_reg && !status.div_busy) state_reg <= ST_COUNT;
                ST_COUNT:  if (status.count_done) begin
                    state_reg <= ST_COMB; first_reg <= 1'b1;
                end
                ST_COMB:   if (!first_reg && !status.mul_busy) begin
                    state_reg <= ST_COMB2; first_reg <= 1'b1;
                end
                ST_COMB2:  if (!first_reg && !status.mul_busy) state_reg <= ST_MASK;
                ST_DPREP:  state_reg <= ST_DCOUNT;
                ST_DCOUNT: if (status.count_done) begin
                    state_reg <= ST_DS1; first_reg <= 1'b1;
                end
                ST_DS1:    if (!first_reg && !status.div_busy) begin
                    state_reg <= ST_DS2; first_reg <= 1'b1;
                end
                ST_DS2:    if (!first_reg && !status.div_busy) begin
                    state_reg <= ST_DFIN; first_reg <= 1'b1;
                end
                ST_DFIN:   if (!first_reg && !status.mul_busy) state_reg <= ST_DONE;
                ST_MASK:   state_reg <= ST_DONE;
                ST_DONE:   if (out_free) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign done    = (state_reg == ST_DONE) && out_free;

    always_comb begin
        cmd.op        = dioc_pkg::OP_NONE;
        cmd.div_start = 1'b0;
        cmd.mul_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd.op = s_valid ? dioc_pkg::OP_LOAD : dioc_pkg::OP_NONE;
            ST_HASH:   cmd.op = dioc_pkg::OP_HASH;
            ST_MUL:    begin cmd.op = dioc_pkg::OP_MUL; cmd.mul_start = first_reg; end
            ST_DIV:    begin cmd.op = dioc_pkg::OP_DIVISOR; cmd.div_start = first_reg; end
            ST_SPLIT:  begin cmd.op = dioc_pkg::OP_SPLIT; cmd.div_start = first_reg; end
            ST_COUNT:  cmd.op = dioc_pkg::OP_COUNT;
            ST_COMB:   begin cmd.op = dioc_pkg::OP_COMBINE; cmd.mul_start = first_reg; end
            ST_COMB2:  begin cmd.op = dioc_pkg::OP_COMBINE2; cmd.mul_start = first_reg; end
            ST_DPREP:  cmd.op = dioc_pkg::OP_DEC_PREP;
            ST_DCOUNT: cmd.op = dioc_pkg::OP_COUNT;
            ST_DS1:    begin cmd.op = dioc_pkg::OP_DEC_SPLIT1; cmd.div_start = first_reg; end
            ST_DS2:    begin cmd.op = dioc_pkg::OP_DEC_SPLIT2; cmd.div_start = first_reg; end
            ST_DFIN:   begin cmd.op = dioc_pkg::OP_DEC_FINAL; cmd.mul_start = first_reg; end
            ST_MASK:   cmd.op = dioc_pkg::OP_MASK_OUT;
            ST_DONE:   cmd.op = dioc_pkg::OP_NONE;
            default:   cmd.op = dioc_pkg::OP_NONE;
        endcase
    end
endmodule

### src/decimal_id_obfuscation_codec.sv
// Decimal id obfuscation codec: encodes a 64-bit value into a decimal public id
// or decodes it back. Input channel s_* (valid/ready, cmd + value), result
// channel m_* (valid/ready, result + bad_input). Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data): 0 secret_key, 1 divisor_digits,
// 2 mask_enable; write only while idle.
// One item at a time. With a free receiver, s_ready rises in the same cycle
// as m_valid. The work is two radix-2 divisions, multiplier passes (three
// on encode, one on decode) and counting the digits of the quotient
// (encode) or of the id (decode), one digit per cycle, 1 to 20 digits.
// Result goes into an output register; the next item is accepted as soon as
// the result is parked there, so a stalled receiver only blocks once a second
// result is ready.
// Reset (aresetn low, synchronous) empties the output register, returns the
// controller to idle and restores secret_key 0, divisor_digits 4, mask off.
// bad_input is 1 on a decode whose id has too few or too many digits; the
// result is then zero.
`include "decimal_id_obfuscation_codec_assert.svh"
module decimal_id_obfuscation_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result,
    output logic        m_bad_input,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [63:0] secret_reg;
    logic [3:0]  digits_reg;
    logic        mask_reg;
    logic        out_vld_reg;
    logic [63:0] out_res_reg;
    logic        out_bad_reg;
    logic        done, out_free;
    logic [63:0] dp_res;
    logic        dp_bad;
    dioc_pkg::dp_cmd_t    cmd;
    dioc_pkg::dp_status_t status;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_reg <= 64'd0;
            digits_reg <= 4'd4;
            mask_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (dioc_pkg::reg_index_t'(cfg_index))
                dioc_pkg::REG_SECRET: secret_reg <= cfg_data;
                dioc_pkg::REG_DIGITS: digits_reg <= cfg_data[3:0];
                dioc_pkg::REG_MASK:   mask_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free = !out_vld_reg || m_ready;

    dioc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_cmd(s_cmd),
        .s_ready(s_ready), .done(done), .out_free(out_free),
        .status(status), .cmd(cmd)
    );

    dioc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_value(s_value), .secret(secret_reg), .digits(digits_reg),
        .mask_en(mask_reg), .res(dp_res), .bad(dp_bad)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (done) begin
            out_vld_reg <= 1'b1;
            out_res_reg <= dp_res;
            out_bad_reg <= dp_bad;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_result    = out_res_reg;
    assign m_bad_input = out_bad_reg;

    `DIOC_ASSERT(a_bad_zero, aclk, aresetn, (m_valid && m_bad_input) |-> (m_result == 64'd0), "bad input with nonzero result")
    `DIOC_ASSERT(a_no_overwrite, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_result), "result overwritten while stalled")
    `DIOC_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")
endmodule

### test/tb_decimal_id_obfuscation_codec.sv
// Testbench for the decimal id obfuscation codec: directed table plus random items,
// checked against an in-bench predictor. Depends on dioc_pkg and the codec top level.
`timescale 1ns / 100ps

module tb_decimal_id_obfuscation_codec;

    typedef struct {
        logic        cmd;
        logic [63:0] value;
        logic        known;       // expected result typed into the row
        logic [63:0] result;
        logic        bad;
    } stim_row_t;

    typedef struct {
        logic [63:0] result;
        logic        bad;
    } codec_out_t;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [63:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result;
    logic        m_bad_input;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // predictor's copy of the registers
    logic [63:0] key_q = '0;
    logic [3:0]  digits_q = 4'd4;
    logic        mask_q = 1'b0;

    codec_out_t  pending_ids[$];
    int          n_fail = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #2 aclk = ~aclk;

    decimal_id_obfuscation_codec uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .m_bad_input(m_bad_input),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------- predictor ----------------
    function automatic logic [63:0] pow10(int e);
        logic [63:0] p;
        p = 64'd1;
        if (e < 0 || e > 18) return 64'd0;
        for (int i = 0; i < e; i++) p = p * 64'd10;
        return p;
    endfunction

    function automatic int num_digits(logic [63:0] v);
        int n;
        n = 1;
        while (v >= 64'd10) begin
            v = v / 64'd10;
            n++;
        end
        return n;
    endfunction

    // XOR with the key every bit below the leading one
    function automatic logic [63:0] mask_low(logic [63:0] v, logic [63:0] s);
        logic [63:0] m;
        int top;
        top = 0;
        for (int i = 63; i > 0; i--)
            if (v[i] && top == 0) top = i;
        m = (64'd1 << top) - 64'd1;
        return (v & ~m) | ((v ^ s) & m);
    endfunction

    function automatic codec_out_t predict_id(logic cmd, logic [63:0] v);
        codec_out_t o;
        int k, n, total;
        logic [63:0] base, h, d, r, q, p1, p2, rest;
        k = (digits_q == 4'd0) ? 1 : int'(digits_q);
        o.result = '0;
        o.bad = 1'b0;
        if (cmd == CMD_ENC) begin
            base = pow10(k - 1);
            h = v;
            h = h ^ (h >> 12);
            h = h ^ (h << 25);
            h = h ^ (h >> 27);
            h = h * (key_q | 64'd1);
            // 9*base is nonzero for every k the 4-bit setting allows (up to 15), so
            // the mod never sees a zero divisor; k above 9 is never written here
            d = h % (64'd9 * base) + base;
            r = v % d;
            q = v / d;
            n = num_digits(q);
            o.result = d * pow10(k + n) + r * pow10(n) + q;
            if (mask_q) o.result = mask_low(o.result, key_q);
        end else begin
            if (mask_q) v = mask_low(v, key_q);
            total = num_digits(v);
            p1 = pow10(total - k);
            p2 = pow10(total - 2 * k);
            if (total < 2 * k + 1 || p1 == 0 || p2 == 0) begin
                o.bad = 1'b1;
            end else begin
                d = v / p1;
                rest = v % p1;
                r = rest / p2;
                q = rest % p2;
                o.result = d * q + r;
            end
        end
        return o;
    endfunction

    // ---------------- driving ----------------
    task automatic write_reg(dioc_pkg::reg_index_t idx, logic [63:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            dioc_pkg::REG_SECRET: key_q = data;
            dioc_pkg::REG_DIGITS: digits_q = data[3:0];
            default:              mask_q = data[0];
        endcase
    endtask

    // one transfer on the input channel, with a random hold-off first;
    // valid stays up after the transfer until the next hold-off or drain
    task automatic send_id(logic cmd, logic [63:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= v;
        pending_ids.push_back(predict_id(cmd, v));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_ids.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        // leave room for any internal tail before touching registers
        repeat (200) @(posedge aclk);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: outputs sampled at the edge, compared in order
    always @(posedge aclk) begin
        codec_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ids.size() == 0) begin
                $display("%0t unexpected result %h bad %b", $time, m_result, m_bad_input);
                n_fail++;
            end else begin
                want = pending_ids.pop_front();
                if (m_result !== want.result) begin
                    $display("%0t result: expected %h actual %h", $time,
                             want.result, m_result);
                    n_fail++;
                end
                if (m_bad_input !== want.bad) begin
                    $display("%0t bad_input: expected %b actual %b", $time,
                             want.bad, m_bad_input);
                    n_fail++;
                end
            end
        end
    end

    // random value: mostly spread over digit counts, some full-width
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return v;
            1: return v % pow10($urandom_range(1, 18));
            default: return v >> $urandom_range(0, 63);
        endcase
    endfunction

    // valid public id under the current settings, built from an encode
    function automatic logic [63:0] make_public_id();
        codec_out_t enc;
        enc = predict_id(CMD_ENC, rand_value());
        return enc.result;
    endfunction

    stim_row_t directed[$];

    task automatic add_row(logic cmd, logic [63:0] v, logic known,
                           logic [63:0] res = '0, logic bad = 1'b0);
        stim_row_t row;
        row.cmd = cmd; row.value = v; row.known = known;
        row.result = res; row.bad = bad;
        directed.push_back(row);
    endtask

    initial begin
        codec_out_t typed;
        int phase;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset settings (key 0, k = 4, no mask)
        add_row(CMD_DEC, 64'd0, 1'b1, 64'd0, 1'b1);               // zero: too few digits
        add_row(CMD_DEC, 64'd12345678, 1'b1, 64'd0, 1'b1);        // 8 digits < 2k+1
        add_row(CMD_DEC, 64'd123456789, 1'b1, 64'd1234 * 64'd9 + 64'd5678, 1'b0);
        add_row(CMD_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);          // 20 digits
        add_row(CMD_ENC, 64'd0, 1'b0);
        add_row(CMD_ENC, 64'd1, 1'b0);
        add_row(CMD_ENC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_row(CMD_ENC, 64'h8000_0000_0000_0000, 1'b0);
        add_row(CMD_ENC, 64'd999999999, 1'b0);
        add_row(CMD_DEC, 64'd1000000000000000000, 1'b0);
        add_row(CMD_DEC, 64'd9999999999999999999, 1'b0);
        add_row(CMD_DEC, 64'h5555_5555_5555_5555, 1'b0);
        add_row(CMD_DEC, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

        foreach (directed[i]) begin
            if (directed[i].known) begin
                typed = predict_id(directed[i].cmd, directed[i].value);
                if (typed.result !== directed[i].result || typed.bad !== directed[i].bad) begin
                    $display("%0t table row %0d: expected %h/%b predicted %h/%b", $time, i,
                             directed[i].result, directed[i].bad, typed.result, typed.bad);
                    n_fail++;
                end
            end
            send_id(directed[i].cmd, directed[i].value);
        end
        drain();

        // extremes of the settings, with masking
        write_reg(dioc_pkg::REG_SECRET, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(dioc_pkg::REG_DIGITS, 64'd1);
        write_reg(dioc_pkg::REG_MASK, 64'd1);
        send_id(CMD_DEC, 64'd0);     // zero stays zero under masking
        send_id(CMD_DEC, 64'd7);
        send_id(CMD_ENC, 64'd0);
        send_id(CMD_ENC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_id(CMD_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        write_reg(dioc_pkg::REG_DIGITS, 64'd0); // zero digits act as one
        send_id(CMD_ENC, 64'd123456);
        send_id(CMD_DEC, 64'd123456);
        drain();
        write_reg(dioc_pkg::REG_DIGITS, 64'd9);
        send_id(CMD_ENC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_id(CMD_DEC, 64'd1234567890123456789);
        drain();

        // random phases: each with its own settings and idling
        for (phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            write_reg(dioc_pkg::REG_SECRET, {$urandom, $urandom});
            write_reg(dioc_pkg::REG_DIGITS, 64'($urandom_range(1, 9)));
            write_reg(dioc_pkg::REG_MASK, 64'($urandom_range(1)));
            repeat (78) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: send_id(CMD_ENC, rand_value());
                    4, 5, 6, 7: send_id(CMD_DEC, make_public_id());
                    default:    send_id(CMD_DEC, rand_value());
                endcase
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (n_fail == 0 && pending_ids.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // overall watchdog
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/dioc_pkg.sv
src/dioc_div.sv
src/dioc_mul.sv
src/dioc_datapath.sv
src/dioc_ctrl.sv
src/decimal_id_obfuscation_codec.sv
test/tb_decimal_id_obfuscation_codec.sv
